// File: rtl/core/tsm_pkg.sv
`default_nettype none

package tsm_pkg;

    localparam int DEF_MAX_ENTRIES = 16;

    localparam int TICK_W  = 31;
    localparam int BAR_W   = 24;
    localparam int NUM_W   = 6;
    localparam int DEN_W   = 7;
    localparam int MEAS_W  = 19;
    localparam int TPQ_W   = 11;
    localparam int BEAT_W  = 6;
    localparam int SUB_W   = 13;
    localparam int TB_W    = 13;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 3;

    // Operand widths of the shared divider.
    localparam int DVD_W   = 31;
    localparam int DVS_W   = 19;

    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 80;

    localparam logic [TPQ_W-1:0]  TPQ_RESET = 11'd480;
    localparam logic [TICK_W-1:0] TICK_MAX  = 31'h7FFF_FFFF;
    localparam logic [BAR_W-1:0]  BAR_MAX   = 24'hFF_FFFF;

    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TO_BAR  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TO_TICK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_DIV   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_SIG  = 3'd4;

    typedef struct packed {
        logic [MEAS_W-1:0] meas;
        logic [BAR_W-1:0]  bar;
        logic [DEN_W-1:0]  nden;
        logic [NUM_W-1:0]  nnum;
        logic [DEN_W-1:0]  den;
        logic [NUM_W-1:0]  num;
        logic [TICK_W-1:0] tick;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/tsm_ram.sv
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tsm_div.sv
`default_nettype none

module tsm_div
    import tsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient,
    output logic      [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic             zero_reg, zero_next;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    // One quotient bit per cycle; the dividend shifts out the top of quo_reg
    // while quotient bits shift in at the bottom.
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        zero_next = zero_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            zero_next = (divisor == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        zero_reg <= zero_next;
    end

    // A zero divisor yields a zero quotient.
    assign done      = done_reg;
    assign quotient  = zero_reg ? '0 : quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/time_signature_map.sv
// Time-signature map: a tick-sorted table of up to MAX_ENTRIES signature
// changes with add, delete, insert-time and remove-time edits, and tick to
// bar/beat/sub-tick conversions in both directions. One request is taken at a
// time; s_tready is low while it runs. Every division goes through one shared
// restoring divider that retires one quotient bit per cycle, and that divider
// sets the pace. An edit copies the table into a second bank and then
// renumbers bars in place with up to two divisions per entry. A conversion
// scans the table and then needs one division (to tick) or three (to bar).
// Results are held in an output register, so the next request is accepted
// while a result still waits on m_tready.
`default_nettype none

module time_signature_map
    import tsm_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tick_in, sig_num, sig_den, nominal_num, nominal_den, bar_in, beat_in,
    // sub_tick_in, length_in, zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]    s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // bar_out, beat_out, sub_tick_out, tick_out, zero fill
    output logic      [M_DATA_W-1:0] m_tdata,
    // status
    output logic      [STAT_W-1:0]   m_tuser,
    input  wire logic                cfg_we,
    input  wire logic [TPQ_W-1:0]    cfg_data
);

    localparam int IW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W  = $bits(entry_t);
    localparam int P1_W   = BAR_W + MEAS_W;
    localparam int SUM_W  = P1_W + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_DECODE  = 21'h000002,
        S_ADD_DIV = 21'h000004,
        S_RB_RD   = 21'h000008,
        S_RB_EV   = 21'h000010,
        S_RB_EV2  = 21'h000020,
        S_RB_END  = 21'h000040,
        S_COMMIT  = 21'h000080,
        S_RN_RD   = 21'h000100,
        S_RN_EV   = 21'h000200,
        S_RN_D1   = 21'h000400,
        S_RN_D2   = 21'h000800,
        S_SC_RD   = 21'h001000,
        S_SC_EV   = 21'h002000,
        S_CV_D1   = 21'h004000,
        S_CV_MUL  = 21'h008000,
        S_CV_NEXT = 21'h010000,
        S_CV_D2   = 21'h020000,
        S_CV_D3   = 21'h040000,
        S_CV_SUM  = 21'h080000,
        S_DONE    = 21'h100000
    } state_t;

    function automatic logic [BAR_W-1:0] sat_bar(input logic [BAR_W-1:0] base,
                                                 input logic [DVD_W-1:0] q);
        logic [DVD_W:0] s;
        s = {{(DVD_W + 1 - BAR_W){1'b0}}, base} + {1'b0, q};
        sat_bar = (s > {{(DVD_W + 1 - BAR_W){1'b0}}, BAR_MAX}) ? BAR_MAX : s[BAR_W-1:0];
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     j_reg, j_next;
    logic              ins_reg, ins_next;
    logic              found_reg, found_next;
    logic              stop_reg, stop_next;
    logic              second_new_reg, second_new_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [TPQ_W-1:0]  tpq_reg;

    // Request fields
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [NUM_W-1:0]  sn_reg, sn_next;
    logic [DEN_W-1:0]  sd_reg, sd_next;
    logic [NUM_W-1:0]  nn_reg, nn_next;
    logic [DEN_W-1:0]  nd_reg, nd_next;
    logic [BAR_W-1:0]  bar_in_reg, bar_in_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    logic [TICK_W-1:0] len_reg, len_next;

    // Work registers
    entry_t            sel_reg, sel_next;
    entry_t            cur_reg, cur_next;
    logic [TICK_W-1:0] prev_reg, prev_next;
    logic [BAR_W-1:0]  bar_acc_reg, bar_acc_next;
    logic [MEAS_W-1:0] tm_reg, tm_next;
    logic [TB_W-1:0]   tb_reg, tb_next;
    logic [MEAS_W-1:0] tmz_reg, tmz_next;
    logic [P1_W-1:0]   p1_reg, p1_next;
    logic [MEAS_W-1:0] p2_reg, p2_next;
    logic [MEAS_W-1:0] new_meas_reg, new_meas_next;
    logic [TICK_W-1:0] last_tick_reg, last_tick_next;

    // Result
    logic [STAT_W-1:0] st_reg, st_next;
    logic [BAR_W-1:0]  bar_o_reg, bar_o_next;
    logic [BEAT_W-1:0] beat_o_reg, beat_o_next;
    logic [SUB_W-1:0]  sub_o_reg, sub_o_next;
    logic [TICK_W-1:0] tick_o_reg, tick_o_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]   m_tuser_reg, m_tuser_next;

    // Divider
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [DVS_W-1:0]  div_r;

    // Table banks
    logic [ENT_W-1:0]  rdata0, rdata1;
    entry_t            rd_entry;
    logic              wr_en;
    logic              wr_bank;
    logic [IW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              place_en;
    entry_t            place_entry;
    logic              rn_we;
    entry_t            rn_data;

    // Datapath helpers
    logic [TPQ_W-1:0]  tpq_eff;
    logic [TB_W-1:0]   whole;
    entry_t            new_entry;
    logic [MEAS_W-1:0] num4;
    logic [MEAS_W-1:0] rn_meas_prod;
    logic [TICK_W:0]   ins_sum;
    logic [TICK_W-1:0] ins_tick;
    logic [TICK_W:0]   rem_end;
    logic [TICK_W-1:0] rn_delta;
    logic [BAR_W-1:0]  bar_diff;
    logic [SUM_W-1:0]  tick_sum;

    assign tpq_eff = (tpq_reg == '0) ? TPQ_W'(1) : tpq_reg;
    assign whole   = {tpq_eff, 2'b00};

    assign new_entry.tick = tick_reg;
    assign new_entry.num  = sn_reg;
    assign new_entry.den  = sd_reg;
    assign new_entry.nnum = nn_reg;
    assign new_entry.nden = nd_reg;
    assign new_entry.bar  = '0;
    assign new_entry.meas = new_meas_reg;

    assign rd_entry     = bank_reg ? entry_t'(rdata1) : entry_t'(rdata0);
    assign num4         = MEAS_W'(whole) * MEAS_W'(sn_reg);
    assign rn_meas_prod = MEAS_W'(whole) * MEAS_W'(cur_reg.num);
    assign ins_sum      = {1'b0, rd_entry.tick} + {1'b0, len_reg};
    assign ins_tick     = (ins_sum > {1'b0, TICK_MAX}) ? TICK_MAX : ins_sum[TICK_W-1:0];
    assign rem_end      = {1'b0, tick_reg} + {1'b0, len_reg};
    assign rn_delta     = (rd_entry.tick >= prev_reg) ? (rd_entry.tick - prev_reg) : '0;
    assign bar_diff     = bar_in_reg - sel_reg.bar;
    assign tick_sum     = SUM_W'(sel_reg.tick) + SUM_W'(p1_reg) + SUM_W'(p2_reg)
                          + SUM_W'(sub_reg);

    always_comb
    begin
        logic merge;

        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        ins_next        = ins_reg;
        found_next      = found_reg;
        stop_next       = stop_reg;
        second_new_next = second_new_reg;
        m_tvalid_next   = m_tvalid_reg;
        req_next        = req_reg;
        tick_next       = tick_reg;
        sn_next         = sn_reg;
        sd_next         = sd_reg;
        nn_next         = nn_reg;
        nd_next         = nd_reg;
        bar_in_next     = bar_in_reg;
        beat_next       = beat_reg;
        sub_next        = sub_reg;
        len_next        = len_reg;
        sel_next        = sel_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        bar_acc_next    = bar_acc_reg;
        tm_next         = tm_reg;
        tb_next         = tb_reg;
        tmz_next        = tmz_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        new_meas_next   = new_meas_reg;
        last_tick_next  = last_tick_reg;
        st_next         = st_reg;
        bar_o_next      = bar_o_reg;
        beat_o_next     = beat_o_reg;
        sub_o_next      = sub_o_reg;
        tick_o_next     = tick_o_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        div_start       = 1'b0;
        div_dvd         = '0;
        div_dvs         = '0;
        place_en        = 1'b0;
        place_entry     = rd_entry;
        rn_we           = 1'b0;
        rn_data         = cur_reg;
        wr_en           = 1'b0;
        wr_bank         = ~bank_reg;
        wr_addr         = idx_reg[IW-1:0];
        wr_data         = cur_reg;
        merge           = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next    = s_tuser;
                    tick_next   = s_tdata[30:0];
                    sn_next     = s_tdata[36:31];
                    sd_next     = s_tdata[43:37];
                    nn_next     = s_tdata[49:44];
                    nd_next     = s_tdata[56:50];
                    bar_in_next = s_tdata[80:57];
                    beat_next   = s_tdata[86:81];
                    sub_next    = s_tdata[99:87];
                    len_next    = s_tdata[130:100];
                    idx_next    = '0;
                    j_next      = '0;
                    ins_next    = 1'b0;
                    found_next  = 1'b0;
                    stop_next   = 1'b0;
                    st_next     = ST_OK;
                    bar_o_next  = '0;
                    beat_o_next = '0;
                    sub_o_next  = '0;
                    tick_o_next = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (req_reg)
                    REQ_ADD:
                    begin
                        if (sn_reg == '0 || sd_reg == '0 || nn_reg == '0 || nd_reg == '0)
                        begin
                            st_next    = ST_ZERO_SIG;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_dvd    = DVD_W'(num4);
                            div_dvs    = DVS_W'(sd_reg);
                            state_next = S_ADD_DIV;
                        end
                    end
                    REQ_DELETE, REQ_INSERT, REQ_REMOVE:
                    begin
                        state_next = S_RB_RD;
                    end
                    REQ_TO_BAR, REQ_TO_TICK:
                    begin
                        state_next = S_SC_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_ADD_DIV:
            begin
                if (div_done)
                begin
                    if (div_r != '0)
                    begin
                        st_next    = ST_BAD_DIV;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        new_meas_next = div_q[MEAS_W-1:0];
                        state_next    = S_RB_RD;
                    end
                end
            end

            // Copy pass from the current bank into the other one.
            S_RB_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_RB_EV : S_RB_END;
            end

            S_RB_EV:
            begin
                state_next = S_RB_RD;
                idx_next   = idx_reg + 1'b1;
                case (req_reg)
                    REQ_ADD:
                    begin
                        if (!ins_reg && rd_entry.tick > tick_reg)
                        begin
                            place_en        = 1'b1;
                            place_entry     = new_entry;
                            ins_next        = 1'b1;
                            second_new_next = 1'b0;
                            idx_next        = idx_reg;
                            state_next      = S_RB_EV2;
                        end
                        else
                        begin
                            place_en = 1'b1;
                            if (!ins_reg && rd_entry.tick == tick_reg)
                            begin
                                // The new entry lands on the same tick and replaces it.
                                ins_next        = 1'b1;
                                found_next      = 1'b1;
                                second_new_next = 1'b1;
                                idx_next        = idx_reg;
                                state_next      = S_RB_EV2;
                            end
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (rd_entry.tick == tick_reg)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            place_en = 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        place_en = 1'b1;
                        if (rd_entry.tick >= tick_reg)
                        begin
                            place_entry.tick = ins_tick;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (rd_entry.tick >= tick_reg && rd_entry.tick != '0)
                        begin
                            if ({1'b0, rd_entry.tick} >= rem_end)
                            begin
                                place_en         = 1'b1;
                                place_entry.tick = rd_entry.tick - len_reg;
                            end
                        end
                        else
                        begin
                            place_en = 1'b1;
                        end
                    end
                    default:
                    begin
                        place_en = 1'b0;
                    end
                endcase
            end

            S_RB_EV2:
            begin
                place_en    = 1'b1;
                place_entry = second_new_reg ? new_entry : rd_entry;
                idx_next    = idx_reg + 1'b1;
                state_next  = S_RB_RD;
            end

            S_RB_END:
            begin
                state_next = S_COMMIT;
                if (req_reg == REQ_ADD)
                begin
                    if (!ins_reg)
                    begin
                        place_en    = 1'b1;
                        place_entry = new_entry;
                    end
                    if (count_reg == MAX_CNT && !found_reg)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                end
                else if (req_reg == REQ_DELETE && !found_reg)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
            end

            S_COMMIT:
            begin
                bank_next    = ~bank_reg;
                count_next   = j_reg;
                idx_next     = '0;
                prev_next    = '0;
                bar_acc_next = '0;
                tm_next      = MEAS_W'(whole);
                state_next   = S_RN_RD;
            end

            // Bar renumbering in place in the current bank.
            S_RN_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_RN_EV : S_DONE;
            end

            S_RN_EV:
            begin
                cur_next   = rd_entry;
                div_start  = 1'b1;
                div_dvd    = rn_delta;
                div_dvs    = tm_reg;
                state_next = S_RN_D1;
            end

            S_RN_D1:
            begin
                if (div_done)
                begin
                    bar_acc_next = sat_bar(bar_acc_reg, div_q);
                    prev_next    = cur_reg.tick;
                    if (cur_reg.num == cur_reg.nnum && cur_reg.den == cur_reg.nden)
                    begin
                        div_start  = 1'b1;
                        div_dvd    = DVD_W'(rn_meas_prod);
                        div_dvs    = DVS_W'(cur_reg.den);
                        state_next = S_RN_D2;
                    end
                    else
                    begin
                        rn_we       = 1'b1;
                        rn_data.bar = sat_bar(bar_acc_reg, div_q);
                        idx_next    = idx_reg + 1'b1;
                        state_next  = S_RN_RD;
                    end
                end
            end

            S_RN_D2:
            begin
                if (div_done)
                begin
                    tm_next      = div_q[MEAS_W-1:0];
                    rn_we        = 1'b1;
                    rn_data.bar  = bar_acc_reg;
                    rn_data.meas = div_q[MEAS_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    state_next   = S_RN_RD;
                end
            end

            // Lookup scan for the conversions.
            S_SC_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_SC_EV;
                end
                else if (!found_reg)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(whole);
                    div_dvs    = DVS_W'(sel_reg.den);
                    state_next = S_CV_D1;
                end
            end

            S_SC_EV:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_SC_RD;
                if (req_reg == REQ_TO_BAR)
                begin
                    if (rd_entry.tick <= tick_reg)
                    begin
                        sel_next   = rd_entry;
                        found_next = 1'b1;
                    end
                end
                else if (!stop_reg)
                begin
                    if (bar_in_reg < rd_entry.bar)
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        sel_next   = rd_entry;
                        found_next = 1'b1;
                    end
                end
            end

            S_CV_D1:
            begin
                if (div_done)
                begin
                    if (sel_reg.den == '0 || div_r != '0
                        || (req_reg == REQ_TO_BAR && sel_reg.num == '0))
                    begin
                        st_next    = ST_BAD_DIV;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        tb_next    = div_q[TB_W-1:0];
                        state_next = S_CV_MUL;
                    end
                end
            end

            S_CV_MUL:
            begin
                tmz_next   = MEAS_W'(tb_reg) * MEAS_W'(sel_reg.num);
                p2_next    = MEAS_W'(tb_reg) * MEAS_W'(beat_reg);
                state_next = S_CV_NEXT;
            end

            S_CV_NEXT:
            begin
                if (req_reg == REQ_TO_BAR)
                begin
                    div_start  = 1'b1;
                    div_dvd    = tick_reg - sel_reg.tick;
                    div_dvs    = tmz_reg;
                    state_next = S_CV_D2;
                end
                else
                begin
                    p1_next    = P1_W'(bar_diff) * P1_W'(tmz_reg);
                    state_next = S_CV_SUM;
                end
            end

            S_CV_D2:
            begin
                if (div_done)
                begin
                    bar_o_next = sat_bar(sel_reg.bar, div_q);
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(div_r);
                    div_dvs    = DVS_W'(tb_reg);
                    state_next = S_CV_D3;
                end
            end

            S_CV_D3:
            begin
                if (div_done)
                begin
                    beat_o_next = div_q[BEAT_W-1:0];
                    sub_o_next  = div_r[SUB_W-1:0];
                    state_next  = S_DONE;
                end
            end

            S_CV_SUM:
            begin
                tick_o_next = (tick_sum > SUM_W'(TICK_MAX)) ? TICK_MAX
                                                            : tick_sum[TICK_W-1:0];
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W - TICK_W - SUB_W - BEAT_W - BAR_W){1'b0}},
                                     tick_o_reg, sub_o_reg, beat_o_reg, bar_o_reg};
                    m_tuser_next  = st_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Append to the copy bank, folding onto the previous slot on an equal tick.
        if (place_en)
        begin
            merge          = (j_reg != '0) && (last_tick_reg == place_entry.tick);
            last_tick_next = place_entry.tick;
            if (merge)
            begin
                wr_addr = IW'(j_reg - 1'b1);
                wr_en   = 1'b1;
            end
            else
            begin
                wr_addr = j_reg[IW-1:0];
                wr_en   = (j_reg < MAX_CNT);
                j_next  = j_reg + 1'b1;
            end
            wr_bank = ~bank_reg;
            wr_data = place_entry;
        end
        else if (rn_we)
        begin
            wr_en   = 1'b1;
            wr_bank = bank_reg;
            wr_addr = idx_reg[IW-1:0];
            wr_data = rn_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bank_reg       <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
            j_reg          <= '0;
            ins_reg        <= 1'b0;
            found_reg      <= 1'b0;
            stop_reg       <= 1'b0;
            second_new_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            tpq_reg        <= TPQ_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            j_reg          <= j_next;
            ins_reg        <= ins_next;
            found_reg      <= found_next;
            stop_reg       <= stop_next;
            second_new_reg <= second_new_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we)
            begin
                tpq_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        tick_reg      <= tick_next;
        sn_reg        <= sn_next;
        sd_reg        <= sd_next;
        nn_reg        <= nn_next;
        nd_reg        <= nd_next;
        bar_in_reg    <= bar_in_next;
        beat_reg      <= beat_next;
        sub_reg       <= sub_next;
        len_reg       <= len_next;
        sel_reg       <= sel_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        bar_acc_reg   <= bar_acc_next;
        tm_reg        <= tm_next;
        tb_reg        <= tb_next;
        tmz_reg       <= tmz_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        new_meas_reg  <= new_meas_next;
        last_tick_reg <= last_tick_next;
        st_reg        <= st_next;
        bar_o_reg     <= bar_o_next;
        beat_o_reg    <= beat_o_next;
        sub_o_reg     <= sub_o_next;
        tick_o_reg    <= tick_o_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    tsm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    tsm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en && !wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata0)
    );

    tsm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en && wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata1)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
    import tsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [TICK_W-1:0] tick;
        logic [NUM_W-1:0]  sn;
        logic [DEN_W-1:0]  sd;
        logic [NUM_W-1:0]  nn;
        logic [DEN_W-1:0]  nd;
        logic [BAR_W-1:0]  bar;
        logic [BEAT_W-1:0] beat;
        logic [SUB_W-1:0]  sub;
        logic [TICK_W-1:0] len;
    } request_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [BAR_W-1:0]  bar;
        logic [BEAT_W-1:0] beat;
        logic [SUB_W-1:0]  sub;
        logic [TICK_W-1:0] tick;
    } answer_t;

    localparam int NSLOT = DEF_MAX_ENTRIES;
    localparam logic [REQ_W-1:0] REQ_NOP_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NOP_B = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // tick_in, sig_num, sig_den, nominal_num, nominal_den, bar_in, beat_in,
    // sub_tick_in, length_in, zero fill
    logic [S_DATA_W-1:0] s_tdata;
    // req_type
    logic [REQ_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // bar_out, beat_out, sub_tick_out, tick_out, zero fill
    logic [M_DATA_W-1:0] m_tdata;
    // status
    logic [STAT_W-1:0]   m_tuser;
    logic                cfg_we;
    logic [TPQ_W-1:0]    cfg_data;

    time_signature_map u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the signature table.
    entry_t           sig_tab [NSLOT];
    int               sig_cnt;
    logic [TPQ_W-1:0] tpq;

    answer_t answer_q [$];
    int      errors;
    int      accepted;
    bit      quiet;
    bit      held_off;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(60_000_000);
        $display("time_signature_map regression: fail");
        $finish;
    end

    function automatic longint unsigned tpq_eff();
        return (tpq == 0) ? 1 : longint'(tpq);
    endfunction

    function automatic longint unsigned bar_len(longint unsigned n, longint unsigned d);
        if (d == 0)
            return 0;
        return (4 * tpq_eff() * n) / d;
    endfunction

    function automatic void renumber_bars();
        longint unsigned tm, prev, bar, t, delta;
        tm = bar_len(4, 4);
        prev = 0;
        bar = 0;
        for (int i = 0; i < sig_cnt; i++) begin
            t = sig_tab[i].tick;
            delta = (t >= prev) ? t - prev : 0;
            bar += (tm != 0) ? delta / tm : 0;
            if (bar > BAR_MAX)
                bar = BAR_MAX;
            sig_tab[i].bar = bar[BAR_W-1:0];
            prev = t;
            if (sig_tab[i].num == sig_tab[i].nnum && sig_tab[i].den == sig_tab[i].nden) begin
                tm = bar_len(sig_tab[i].num, sig_tab[i].den);
                sig_tab[i].meas = tm[MEAS_W-1:0];
            end
        end
    endfunction

    // Compacting write used by insert and remove: a later entry landing on
    // the same tick as the last written one replaces it.
    function automatic void compact_put(ref int j, input int src, input longint unsigned nt);
        int d;
        entry_t e;
        d = j;
        e = sig_tab[src];
        if (d > 0 && sig_tab[d-1].tick == nt[TICK_W-1:0])
            d = d - 1;
        else
            j = d + 1;
        e.tick = nt[TICK_W-1:0];
        sig_tab[d] = e;
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        longint unsigned num4, w, tb, tmz, delta, v, stop;
        int at, k, j;
        a = '{default: '0};
        case (r.req)
            REQ_ADD: begin
                num4 = 4 * tpq_eff() * r.sn;
                if (r.sn == 0 || r.sd == 0 || r.nn == 0 || r.nd == 0)
                    a.status = ST_ZERO_SIG;
                else if (num4 % r.sd != 0)
                    a.status = ST_BAD_DIV;
                else begin
                    at = -1;
                    for (int i = 0; i < sig_cnt; i++)
                        if (sig_tab[i].tick == r.tick)
                            at = i;
                    if (at < 0) begin
                        if (sig_cnt >= NSLOT)
                            a.status = ST_FULL;
                        else begin
                            at = 0;
                            while (at < sig_cnt && sig_tab[at].tick < r.tick)
                                at++;
                            for (int i = sig_cnt; i > at; i--)
                                sig_tab[i] = sig_tab[i-1];
                            sig_cnt++;
                        end
                    end
                    if (a.status == ST_OK) begin
                        v = num4 / r.sd;
                        sig_tab[at] = '{meas: v[MEAS_W-1:0], bar: '0, nden: r.nd,
                                        nnum: r.nn, den: r.sd, num: r.sn, tick: r.tick};
                        renumber_bars();
                    end
                end
            end
            REQ_DELETE: begin
                at = -1;
                for (int i = 0; i < sig_cnt; i++)
                    if (sig_tab[i].tick == r.tick)
                        at = i;
                if (at < 0)
                    a.status = ST_NOT_FOUND;
                else begin
                    for (int i = at; i + 1 < sig_cnt; i++)
                        sig_tab[i] = sig_tab[i+1];
                    sig_cnt--;
                    renumber_bars();
                end
            end
            REQ_TO_BAR: begin
                k = -1;
                for (int i = 0; i < sig_cnt; i++)
                    if (sig_tab[i].tick <= r.tick)
                        k = i;
                w = 4 * tpq_eff();
                if (k < 0)
                    a.status = ST_NOT_FOUND;
                else if (sig_tab[k].den == 0 || w % sig_tab[k].den != 0 || sig_tab[k].num == 0)
                    a.status = ST_BAD_DIV;
                else begin
                    tb = w / sig_tab[k].den;
                    tmz = tb * sig_tab[k].num;
                    delta = r.tick - sig_tab[k].tick;
                    v = sig_tab[k].bar + delta / tmz;
                    if (v > BAR_MAX)
                        v = BAR_MAX;
                    a.bar = v[BAR_W-1:0];
                    v = (delta % tmz) / tb;
                    a.beat = v[BEAT_W-1:0];
                    v = (delta % tmz) % tb;
                    a.sub = v[SUB_W-1:0];
                end
            end
            REQ_TO_TICK: begin
                k = -1;
                for (int i = 0; i < sig_cnt; i++) begin
                    if (r.bar < sig_tab[i].bar)
                        break;
                    k = i;
                end
                w = 4 * tpq_eff();
                if (k < 0)
                    a.status = ST_NOT_FOUND;
                else if (sig_tab[k].den == 0 || w % sig_tab[k].den != 0)
                    a.status = ST_BAD_DIV;
                else begin
                    tb = w / sig_tab[k].den;
                    tmz = tb * sig_tab[k].num;
                    v = sig_tab[k].tick + (r.bar - sig_tab[k].bar) * tmz + tb * r.beat + r.sub;
                    if (v > TICK_MAX)
                        v = TICK_MAX;
                    a.tick = v[TICK_W-1:0];
                end
            end
            REQ_INSERT: begin
                j = 0;
                for (int i = 0; i < sig_cnt; i++) begin
                    v = sig_tab[i].tick;
                    if (v >= r.tick) begin
                        v += r.len;
                        if (v > TICK_MAX)
                            v = TICK_MAX;
                    end
                    compact_put(j, i, v);
                end
                sig_cnt = j;
                renumber_bars();
            end
            REQ_REMOVE: begin
                stop = longint'(r.tick) + r.len;
                j = 0;
                for (int i = 0; i < sig_cnt; i++) begin
                    v = sig_tab[i].tick;
                    if (v >= r.tick && v != 0) begin
                        if (v >= stop)
                            compact_put(j, i, v - r.len);
                    end else
                        compact_put(j, i, v);
                end
                sig_cnt = j;
                renumber_bars();
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic request_t mk(logic [REQ_W-1:0] req, longint unsigned tick,
                                    int sn, int sd, int nn, int nd, longint unsigned bar,
                                    int beat, int sub, longint unsigned len);
        request_t r;
        r = '{req: req, tick: tick[TICK_W-1:0], sn: sn[NUM_W-1:0], sd: sd[DEN_W-1:0],
              nn: nn[NUM_W-1:0], nd: nd[DEN_W-1:0], bar: bar[BAR_W-1:0],
              beat: beat[BEAT_W-1:0], sub: sub[SUB_W-1:0], len: len[TICK_W-1:0]};
        return r;
    endfunction

    function automatic longint unsigned near_tick();
        longint signed t;
        if (sig_cnt > 0 && $urandom_range(2) != 0) begin
            t = sig_tab[$urandom_range(sig_cnt - 1)].tick;
            t += longint'($urandom_range(10000)) - 5000;
            if (t < 0)
                t = 0;
            if (t > TICK_MAX)
                t = TICK_MAX;
            return t;
        end
        if ($urandom_range(9) == 0)
            return $urandom() & TICK_MAX;
        return $urandom_range(200000);
    endfunction

    function automatic longint unsigned some_len();
        if ($urandom_range(9) == 0)
            return $urandom() & TICK_MAX;
        return $urandom_range(20000);
    endfunction

    function automatic request_t random_request();
        request_t r;
        int pick, sd, sn, nn, nd;
        pick = $urandom_range(99);
        r = mk(REQ_ADD, near_tick(), 0, 0, 0, 0, 0, 0, 0, 0);
        if (pick < 35) begin
            sd = 1 << $urandom_range(6);
            sn = $urandom_range(1, 63);
            if ($urandom_range(19) == 0)
                sd = $urandom_range(64);
            if ($urandom_range(19) == 0)
                sn = $urandom_range(63);
            nn = sn;
            nd = sd;
            if ($urandom_range(3) == 0) begin
                nn = $urandom_range(63);
                nd = $urandom_range(64);
            end
            r.sn = sn[NUM_W-1:0];
            r.sd = sd[DEN_W-1:0];
            r.nn = nn[NUM_W-1:0];
            r.nd = nd[DEN_W-1:0];
        end else if (pick < 45) begin
            r.req = REQ_DELETE;
        end else if (pick < 65) begin
            r.req = REQ_TO_BAR;
        end else if (pick < 80) begin
            r.req = REQ_TO_TICK;
            if (sig_cnt > 0 && $urandom_range(4) != 0)
                r.bar = BAR_W'(sig_tab[$urandom_range(sig_cnt - 1)].bar + $urandom_range(20));
            else
                r.bar = BAR_W'($urandom());
            r.beat = BEAT_W'($urandom_range(63));
            r.sub = SUB_W'($urandom_range(7679));
        end else if (pick < 88) begin
            r.req = REQ_INSERT;
            r.len = TICK_W'(some_len());
        end else if (pick < 97) begin
            r.req = REQ_REMOVE;
            r.len = TICK_W'(some_len());
        end else begin
            r = mk(REQ_W'($urandom_range(7)), $urandom(), $urandom_range(63),
                   $urandom_range(64), $urandom_range(63), $urandom_range(64), $urandom(),
                   $urandom_range(63), $urandom_range(7679), $urandom());
        end
        return r;
    endfunction

    task automatic send_request(request_t r, bit typed, answer_t typed_ans);
        int gap;
        answer_t a;
        gap = quiet ? 0 : (($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req;
        s_tdata  <= {5'b0, r.len, r.sub, r.beat, r.bar, r.nd, r.nn, r.sd, r.sn, r.tick};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        a = apply_request(r);
        answer_q.push_back(typed ? typed_ans : a);
        accepted++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Result side: random back-pressure, plus one long hold-off so the block
    // fills its output register and stops taking requests.
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held_off && accepted > 200) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (3000) @(negedge clk);
            end else if (!quiet && $urandom_range(2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    always @(posedge clk) begin
        answer_t e, got;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{status: m_tuser, bar: m_tdata[23:0], beat: m_tdata[29:24],
                    sub: m_tdata[42:30], tick: m_tdata[73:43]};
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected beat status=%0d", $time, got.status);
                errors++;
            end else begin
                e = answer_q.pop_front();
                if (got.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                    errors++;
                end
                if (got.bar !== e.bar) begin
                    $display("%0t: bar_out exp %0d got %0d", $time, e.bar, got.bar);
                    errors++;
                end
                if (got.beat !== e.beat) begin
                    $display("%0t: beat_out exp %0d got %0d", $time, e.beat, got.beat);
                    errors++;
                end
                if (got.sub !== e.sub) begin
                    $display("%0t: sub_tick_out exp %0d got %0d", $time, e.sub, got.sub);
                    errors++;
                end
                if (got.tick !== e.tick) begin
                    $display("%0t: tick_out exp %0d got %0d", $time, e.tick, got.tick);
                    errors++;
                end
            end
        end
    end

    initial begin
        request_t   rows [18];
        bit         typed [18];
        answer_t    typed_ans [18];
        int         tpq_steps [6];
        answer_t    ok;
        answer_t    nf;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        errors   = 0;
        accepted = 0;
        quiet    = 1'b0;
        held_off = 1'b0;
        sig_cnt  = 0;
        tpq      = TPQ_RESET;
        rst_n    = 1'b0;

        ok = '{default: '0};
        nf = '{status: ST_NOT_FOUND, default: '0};
        rows = '{
            mk(REQ_TO_BAR,  0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_DELETE,  100, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_TO_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_ADD,     0, 0, 4, 4, 4, 0, 0, 0, 0),
            mk(REQ_ADD,     0, 3, 7, 3, 7, 0, 0, 0, 0),
            mk(REQ_ADD,     0, 4, 4, 4, 4, 0, 0, 0, 0),
            mk(REQ_TO_BAR,  6245, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_TO_TICK, 0, 0, 0, 0, 0, 3, 1, 5, 0),
            mk(REQ_ADD,     TICK_MAX, 63, 64, 63, 64, 0, 0, 0, 0),
            mk(REQ_TO_BAR,  TICK_MAX, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_TO_TICK, 0, 0, 0, 0, 0, BAR_MAX, 63, 7679, 0),
            mk(REQ_ADD,     1000, 7, 8, 3, 4, 0, 0, 0, 0),
            mk(REQ_INSERT,  1, 0, 0, 0, 0, 0, 0, 0, TICK_MAX),
            mk(REQ_REMOVE,  0, 0, 0, 0, 0, 0, 0, 0, 500),
            mk(REQ_NOP_A,   77, 63, 64, 63, 64, BAR_MAX, 63, 7679, TICK_MAX),
            mk(REQ_NOP_B,   0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_DELETE,  0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(REQ_TO_BAR,  5, 0, 0, 0, 0, 0, 0, 0, 0)
        };
        typed = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0};
        typed_ans = '{nf, nf, nf, ok, ok, ok, ok, ok, ok, ok, ok, ok, ok, ok, ok, ok, ok, ok};
        typed_ans[3].status = ST_ZERO_SIG;
        typed_ans[4].status = ST_BAD_DIV;
        // 6245 = 3 bars of 1920, one beat of 480 and 5 ticks.
        typed_ans[6] = '{status: ST_OK, bar: 3, beat: 1, sub: 5, tick: 0};
        typed_ans[7] = '{status: ST_OK, bar: 0, beat: 0, sub: 0, tick: 6245};
        tpq_steps = '{1920, 1, 960, 1919, 7, 480};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_request(rows[i], typed[i], typed_ans[i]);
        drain();

        foreach (tpq_steps[p]) begin
            @(negedge clk);
            cfg_we   <= 1'b1;
            cfg_data <= TPQ_W'(tpq_steps[p]);
            @(negedge clk);
            cfg_we   <= 1'b0;
            tpq = TPQ_W'(tpq_steps[p]);
            if (p == 5)
                quiet = 1'b1;
            repeat (280)
                send_request(random_request(), 1'b0, ok);
            drain();
        end

        if (errors == 0)
            $display("time_signature_map regression: pass");
        else
            $display("time_signature_map regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
